/* sv/mcms_pkg.sv */
package mcms_pkg;

  // field widths
  localparam int unsigned SideW  = 13;
  localparam int unsigned LevelW = 4;
  localparam int unsigned BytesW = 27;
  localparam int unsigned ShW    = 3;

  // default largest side in pixels
  localparam int unsigned MaxDimDefault = 4096;

  // format class codes
  localparam logic [1:0] FmtPlain = 2'd0;
  localparam logic [1:0] FmtDxt1  = 2'd1;
  localparam logic [1:0] FmtDxt35 = 2'd2;

  // log2 of bytes per block for each format
  localparam logic [ShW-1:0] ShPlain = 3'd2;
  localparam logic [ShW-1:0] ShDxt1  = 3'd3;
  localparam logic [ShW-1:0] ShDxt35 = 3'd4;

  // largest side that fits in one compressed block
  localparam logic [SideW-1:0] BlockSide = 13'd4;

  // input item
  typedef struct packed {
    logic [SideW-1:0] width;
    logic [SideW-1:0] height;
    logic [1:0]       format_class;
    logic             mipmapped;
  } mcms_in_t;

  // result item
  typedef struct packed {
    logic [LevelW-1:0] top_level;
    logic [BytesW-1:0] base_bytes;
    logic [BytesW-1:0] total_bytes;
  } mcms_out_t;

  // one level request from the sequencer to the multiply-accumulate unit
  typedef struct packed {
    logic             issue;
    logic             first;
    logic             last;
    logic [SideW-1:0] blk_w;
    logic [SideW-1:0] blk_h;
    logic [ShW-1:0]   sh;
  } mcms_mac_req_t;

  // sequencer states
  typedef enum logic [2:0] {
    StIdle  = 3'b001,
    StRun   = 3'b010,
    StFlush = 3'b100
  } mcms_state_e;

endpackage

/* sv/mcms_mac.sv */
module mcms_mac (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  mcms_pkg::mcms_mac_req_t     req_i,
  output logic                        done_o,
  output logic [mcms_pkg::BytesW-1:0] base_o,
  output logic [mcms_pkg::BytesW-1:0] total_o
);

  localparam int unsigned MulW = 2 * mcms_pkg::SideW;
  localparam int unsigned ScW  = MulW + 4;

  logic [MulW-1:0]             mul;
  logic [ScW-1:0]              scaled;
  logic [mcms_pkg::BytesW-1:0] prod_d, prod_q;
  logic                        prod_vld_q, prod_first_q, prod_last_q;
  logic [mcms_pkg::BytesW-1:0] acc_d, acc_q, base_d, base_q;
  logic                        done_d, done_q;

  // block count product scaled by bytes per block
  assign mul    = MulW'(req_i.blk_w) * MulW'(req_i.blk_h);
  assign scaled = ScW'(mul) << req_i.sh;
  assign prod_d = scaled[mcms_pkg::BytesW-1:0];

  // product stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q   <= 1'b0;
      prod_first_q <= 1'b0;
      prod_last_q  <= 1'b0;
    end else begin
      prod_vld_q   <= req_i.issue;
      prod_first_q <= req_i.first;
      prod_last_q  <= req_i.last;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  // accumulate, the first level also gives the base size
  always_comb begin
    acc_d  = acc_q;
    base_d = base_q;
    done_d = 1'b0;
    if (prod_vld_q) begin
      done_d = prod_last_q;
      if (prod_first_q) begin
        acc_d  = prod_q;
        base_d = prod_q;
      end else begin
        acc_d = acc_q + prod_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    base_q <= base_d;
  end

  assign done_o  = done_q;
  assign base_o  = base_q;
  assign total_o = acc_q;

endmodule

/* sv/mcms_seq.sv */
module mcms_seq #(
  parameter int unsigned MAX_DIM = mcms_pkg::MaxDimDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  input  mcms_pkg::mcms_in_t           in_i,
  output logic                         busy,
  output mcms_pkg::mcms_mac_req_t      req_o,
  output logic [mcms_pkg::LevelW-1:0]  level_o
);

  localparam int unsigned CmpW = mcms_pkg::SideW + 2;
  localparam logic [CmpW-1:0] MaxDimC = CmpW'(MAX_DIM);

  mcms_pkg::mcms_state_e state_d, state_q;

  logic [mcms_pkg::SideW-1:0]  w_d, w_q, h_d, h_q;
  logic [mcms_pkg::LevelW-1:0] level_d, level_q;
  logic                        mip_d, mip_q, cmp_d, cmp_q;
  logic [mcms_pkg::ShW-1:0]    sh_d, sh_q;
  logic [mcms_pkg::SideW-1:0]  w_clamp, h_clamp;
  logic [mcms_pkg::SideW:0]    w_round, h_round;
  logic                        fits;
  logic                        accept;

  assign accept = start && !busy;

  // clamp sides to 1..MAX_DIM
  always_comb begin
    w_clamp = in_i.width;
    h_clamp = in_i.height;
    if (w_clamp == '0) begin
      w_clamp = mcms_pkg::SideW'(1);
    end
    if (h_clamp == '0) begin
      h_clamp = mcms_pkg::SideW'(1);
    end
    if (CmpW'(w_clamp) > MaxDimC) begin
      w_clamp = mcms_pkg::SideW'(MAX_DIM);
    end
    if (CmpW'(h_clamp) > MaxDimC) begin
      h_clamp = mcms_pkg::SideW'(MAX_DIM);
    end
  end

  // block counts per side, rounded up for compressed formats
  assign w_round = ({1'b0, w_q} + (mcms_pkg::SideW + 1)'(3)) >> 2;
  assign h_round = ({1'b0, h_q} + (mcms_pkg::SideW + 1)'(3)) >> 2;

  // chain ends once both sides fit in one block
  assign fits = cmp_q ? ((w_q <= mcms_pkg::BlockSide) && (h_q <= mcms_pkg::BlockSide))
                      : ((w_q == mcms_pkg::SideW'(1)) && (h_q == mcms_pkg::SideW'(1)));

  // level sequencer
  always_comb begin
    state_d = state_q;
    w_d     = w_q;
    h_d     = h_q;
    level_d = level_q;
    mip_d   = mip_q;
    cmp_d   = cmp_q;
    sh_d    = sh_q;

    req_o.issue = 1'b0;
    req_o.first = (level_q == '0);
    req_o.last  = !(mip_q && !fits);
    req_o.blk_w = cmp_q ? w_round[mcms_pkg::SideW-1:0] : w_q;
    req_o.blk_h = cmp_q ? h_round[mcms_pkg::SideW-1:0] : h_q;
    req_o.sh    = sh_q;

    unique case (state_q)
      mcms_pkg::StIdle: begin
        if (accept) begin
          w_d     = w_clamp;
          h_d     = h_clamp;
          level_d = '0;
          mip_d   = in_i.mipmapped;
          unique case (in_i.format_class)
            mcms_pkg::FmtDxt1: begin
              cmp_d = 1'b1;
              sh_d  = mcms_pkg::ShDxt1;
            end
            mcms_pkg::FmtDxt35: begin
              cmp_d = 1'b1;
              sh_d  = mcms_pkg::ShDxt35;
            end
            default: begin
              cmp_d = 1'b0;
              sh_d  = mcms_pkg::ShPlain;
            end
          endcase
          state_d = mcms_pkg::StRun;
        end
      end
      mcms_pkg::StRun: begin
        req_o.issue = 1'b1;
        if (req_o.last) begin
          state_d = mcms_pkg::StFlush;
        end else begin
          w_d     = (w_q > mcms_pkg::SideW'(1)) ? (w_q >> 1) : mcms_pkg::SideW'(1);
          h_d     = (h_q > mcms_pkg::SideW'(1)) ? (h_q >> 1) : mcms_pkg::SideW'(1);
          level_d = level_q + mcms_pkg::LevelW'(1);
        end
      end
      mcms_pkg::StFlush: begin
        state_d = mcms_pkg::StIdle;
      end
      default: begin
        state_d = mcms_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mcms_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q     <= w_d;
    h_q     <= h_d;
    level_q <= level_d;
    mip_q   <= mip_d;
    cmp_q   <= cmp_d;
    sh_q    <= sh_d;
  end

  assign busy    = (state_q != mcms_pkg::StIdle);
  assign level_o = level_q;

endmodule

/* sv/mip_chain_memory_size.sv */
// Mip chain memory sizer. Pulse start while busy is low with the texture's
// level-0 width, height, format class and mipmapped flag on in_i; one result
// comes back on res_o, marked by res_valid_o for a single cycle, and must be
// taken then since the block cannot hold it. The result gives the top mip
// level, the bytes of level 0 and the bytes of all stored levels. One shared
// multiplier sizes one mip level per cycle, so busy stays high while the levels
// are issued and through the flush state; the next item can be taken once busy
// is low again, even before the previous result has passed the product,
// accumulate and result registers to its strobe.
module mip_chain_memory_size #(
  parameter int unsigned MAX_DIM = mcms_pkg::MaxDimDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  mcms_pkg::mcms_in_t  in_i,
  output logic                res_valid_o,
  output mcms_pkg::mcms_out_t res_o
);

  mcms_pkg::mcms_mac_req_t     mac_req;
  logic [mcms_pkg::LevelW-1:0] level;
  logic                        mac_done;
  logic [mcms_pkg::BytesW-1:0] base_bytes, total_bytes;
  logic                        res_valid_q;
  mcms_pkg::mcms_out_t         res_q;

  // level sequencer
  mcms_seq #(
    .MAX_DIM(MAX_DIM)
  ) u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .in_i   (in_i),
    .busy   (busy),
    .req_o  (mac_req),
    .level_o(level)
  );

  // shared multiply-accumulate unit
  mcms_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mac_req),
    .done_o (mac_done),
    .base_o (base_bytes),
    .total_o(total_bytes)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= mac_done;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mac_done) begin
      res_q.top_level   <= level;
      res_q.base_bytes  <= base_bytes;
      res_q.total_bytes <= total_bytes;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule
